// File: rtl/sds_pkg.sv
// ============================================================================
// sds_pkg - shared definitions for the strongest device selector
// Widths, register indexes, reset values and the structs that pass between
// the register file, the engine and the address table memory.
// ============================================================================
package sds_pkg;

   // Address table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   // Field widths
   localparam int ADDR_W    = 48;
   localparam int RSSI_W    = 8;
   localparam int CLASS_W   = 24;
   localparam int WINDOW_W  = 20;
   localparam int ELAPSED_W = 21;
   localparam int STORED_W  = 5;

   // Register port
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   // Request command codes
   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      REG_CLASS_MASK    = 2'd0,
      REG_CLASS_MATCH   = 2'd1,
      REG_SEARCH_WINDOW = 2'd2
   } reg_index_type;

   // Register reset values
   localparam logic [CLASS_W-1:0]  CLASS_MASK_RST  = 24'hFFF000;
   localparam logic [CLASS_W-1:0]  CLASS_MATCH_RST = 24'h240000;
   localparam logic [WINDOW_W-1:0] WINDOW_RST      = 20'd15000;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   // Configuration seen by the engine
   typedef struct packed {
      logic [CLASS_W-1:0]  class_mask;
      logic [CLASS_W-1:0]  class_match;
      logic [WINDOW_W-1:0] search_window_ms;
   } cfg_type;

   // Engine to address table memory
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic [ADDR_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_idx;
   } mem_req_type;

endpackage

// File: rtl/sds_if.sv
// ============================================================================
// sds_if - request and response channel interfaces
// Valid/ready channels; a transfer happens when valid and ready are high.
// ============================================================================
interface sds_req_if;
   import sds_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [ADDR_W-1:0]          device_address;
   logic signed [RSSI_W-1:0]   signal_strength;
   logic [CLASS_W-1:0]         device_class;

   modport source (output valid, command, device_address, signal_strength, device_class,
                   input ready);
   modport sink   (input valid, command, device_address, signal_strength, device_class,
                   output ready);
endinterface

interface sds_rsp_if;
   import sds_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       connect_now;
   logic                       newly_stored;
   logic [STORED_W-1:0]        stored_count;
   logic                       best_known;
   logic signed [RSSI_W-1:0]   best_strength;

   modport source (output valid, connect_now, newly_stored, stored_count, best_known,
                   best_strength, input ready);
   modport sink   (input valid, connect_now, newly_stored, stored_count, best_known,
                   best_strength, output ready);
endinterface

// File: rtl/sds_table_mem.sv
// ============================================================================
// sds_table_mem - address table storage
// One write port and one read port; read data is registered.
// ============================================================================
module sds_table_mem (
   input  logic                       clock,
   input  sds_pkg::mem_req_type       mem_req,
   output logic [sds_pkg::ADDR_W-1:0] rd_data
);
   import sds_pkg::*;

   logic [ADDR_W-1:0] entry_mem [TABLE_ENTRIES];
   logic [ADDR_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.wr_idx] <= mem_req.wr_data;
      end
      rd_data_ff <= entry_mem[mem_req.rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sds_csr.sv
// ============================================================================
// sds_csr - configuration registers
// APB-style write and read of the class mask, class match and window length.
// ============================================================================
module sds_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sds_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [sds_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [sds_pkg::PDATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output sds_pkg::cfg_type            cfg
);
   import sds_pkg::*;

   logic [CLASS_W-1:0]  class_mask_ff;
   logic [CLASS_W-1:0]  class_match_ff;
   logic [WINDOW_W-1:0] window_ff;
   logic [1:0]          reg_idx;
   logic                wr_stb;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         class_mask_ff  <= CLASS_MASK_RST;
         class_match_ff <= CLASS_MATCH_RST;
         window_ff      <= WINDOW_RST;
      end else if (wr_stb) begin
         case (reg_idx)
            REG_CLASS_MASK:    class_mask_ff  <= csr_pwdata[CLASS_W-1:0];
            REG_CLASS_MATCH:   class_match_ff <= csr_pwdata[CLASS_W-1:0];
            REG_SEARCH_WINDOW: window_ff      <= csr_pwdata[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_CLASS_MASK:    csr_prdata = PDATA_W'(class_mask_ff);
         REG_CLASS_MATCH:   csr_prdata = PDATA_W'(class_match_ff);
         REG_SEARCH_WINDOW: csr_prdata = PDATA_W'(window_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.class_mask       = class_mask_ff;
   assign cfg.class_match      = class_match_ff;
   assign cfg.search_window_ms = window_ff;

endmodule

// File: rtl/sds_engine.sv
// ============================================================================
// sds_engine - request sequencer
// Classifies each request, scans the address table for duplicates, updates
// the count, best-signal tracking and elapsed time, and loads the response.
// ============================================================================
module sds_engine (
   input  logic                       clock,
   input  logic                       reset,
   sds_req_if.sink                    req_chan,
   sds_rsp_if.source                  rsp_chan,
   input  sds_pkg::cfg_type           cfg,
   output sds_pkg::mem_req_type       mem_req,
   input  logic [sds_pkg::ADDR_W-1:0] rd_data
);
   import sds_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;

   // captured request
   logic                     cmd_ff, cmd_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic                     hit_ff, hit_in;
   logic                     late_ff, late_in;

   // scan control
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     cmpv_ff, cmpv_in;
   logic                     found_ff, found_in;

   // block state
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     best_valid_ff, best_valid_in;
   logic signed [RSSI_W-1:0] best_rssi_ff, best_rssi_in;
   logic [ADDR_W-1:0]        best_addr_ff, best_addr_in;
   logic [ELAPSED_W-1:0]     elapsed_ff, elapsed_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     connect_ff, connect_in;
   logic                     stored_ff, stored_in;
   logic [STORED_W-1:0]      scount_ff, scount_in;
   logic                     known_ff, known_in;
   logic signed [RSSI_W-1:0] strength_ff, strength_in;

   logic accept, class_hit, late, room, issuing, slot_free;
   logic collect, add, connect;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign class_hit      = (req_chan.device_class & cfg.class_mask) == cfg.class_match;
   assign late           = elapsed_ff > ELAPSED_W'(cfg.search_window_ms);
   assign room           = count_ff < CNT_W'(TABLE_ENTRIES);
   assign issuing        = issue_ff < count_ff;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // decisions on the captured request
   assign collect = (cmd_ff == CMD_REPORT) && hit_ff && !late_ff;
   assign add     = collect && room && !found_ff;
   assign connect = (cmd_ff == CMD_REPORT) && hit_ff && late_ff && best_valid_ff &&
                    (addr_ff == best_addr_ff);

   // table port
   always_comb begin
      mem_req.rd_idx  = issue_ff[IDX_W-1:0];
      mem_req.wr_idx  = count_ff[IDX_W-1:0];
      mem_req.wr_data = addr_ff;
      mem_req.wr_en   = (state_ff == ST_FINISH) && slot_free && add;
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      rssi_in       = rssi_ff;
      hit_in        = hit_ff;
      late_in       = late_ff;
      issue_in      = issue_ff;
      cmpv_in       = 1'b0;
      found_in      = found_ff;
      count_in      = count_ff;
      best_valid_in = best_valid_ff;
      best_rssi_in  = best_rssi_ff;
      best_addr_in  = best_addr_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      connect_in    = connect_ff;
      stored_in     = stored_ff;
      scount_in     = scount_ff;
      known_in      = known_ff;
      strength_in   = strength_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_chan.command;
               addr_in  = req_chan.device_address;
               rssi_in  = req_chan.signal_strength;
               hit_in   = class_hit;
               late_in  = late;
               issue_in = '0;
               found_in = 1'b0;
               if ((req_chan.command == CMD_REPORT) && class_hit && !late && room &&
                   (count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         // one read issued per cycle, compared in the following cycle
         ST_SCAN: begin
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
            end
            cmpv_in = issuing;
            if (cmpv_ff && (rd_data == addr_ff)) begin
               found_in = 1'b1;
            end
            if (!issuing && !cmpv_ff) begin
               state_in = ST_FINISH;
            end
         end

         // commit and load the response once the output slot frees
         ST_FINISH: begin
            if (slot_free) begin
               if ((cmd_ff == CMD_TICK) && (elapsed_ff != ELAPSED_MAX)) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               if (add) begin
                  count_in = count_ff + 1'b1;
                  if (!best_valid_ff || (rssi_ff > best_rssi_ff)) begin
                     best_valid_in = 1'b1;
                     best_rssi_in  = rssi_ff;
                     best_addr_in  = addr_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               connect_in   = connect;
               stored_in    = add;
               scount_in    = STORED_W'(count_in);
               known_in     = best_valid_in;
               strength_in  = best_valid_in ? best_rssi_in : '0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmpv_ff       <= 1'b0;
         count_ff      <= '0;
         best_valid_ff <= 1'b0;
         best_rssi_ff  <= '0;
         best_addr_ff  <= '0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         addr_ff       <= addr_in;
         rssi_ff       <= rssi_in;
         hit_ff        <= hit_in;
         late_ff       <= late_in;
         issue_ff      <= issue_in;
         cmpv_ff       <= cmpv_in;
         found_ff      <= found_in;
         count_ff      <= count_in;
         best_valid_ff <= best_valid_in;
         best_rssi_ff  <= best_rssi_in;
         best_addr_ff  <= best_addr_in;
         elapsed_ff    <= elapsed_in;
         rsp_valid_ff  <= rsp_valid_in;
         connect_ff    <= connect_in;
         stored_ff     <= stored_in;
         scount_ff     <= scount_in;
         known_ff      <= known_in;
         strength_ff   <= strength_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.connect_now   = connect_ff;
   assign rsp_chan.newly_stored  = stored_ff;
   assign rsp_chan.stored_count  = scount_ff;
   assign rsp_chan.best_known    = known_ff;
   assign rsp_chan.best_strength = strength_ff;

endmodule

// File: rtl/strongest_device_selector_unit.sv
// ============================================================================
// strongest_device_selector_unit - top level
// Filters discovery reports by class, collects new addresses during the
// search window while tracking the strongest one, then flags reconnection.
// ============================================================================
//
//   channel   | direction | handshake      | payload
//   ----------+-----------+----------------+-----------------------------------
//   req_chan  | in        | valid/ready    | command, device_address,
//             |           |                | signal_strength, device_class
//   rsp_chan  | out       | valid/ready    | connect_now, newly_stored,
//             |           |                | stored_count, best_known, best_strength
//   csr_*     | in/out    | APB, pready=1  | class_mask, class_match, search_window_ms
//
// Ticks, dropped and post-window reports, and reports to a full or empty table
// go straight from idle to the finish state; a report inside the window with
// stored addresses first walks the table's single read port one entry a cycle.
// One request is in work at a time; the next is taken while the previous
// response still waits in its register.
// Reset is synchronous; the table needs no clearing pass since only entries
// below the count are read. A stalled response holds the engine in its
// final state and the response register keeps its value.
//
module strongest_device_selector_unit (
   input  logic                        clock,
   input  logic                        reset,
   sds_req_if.sink                     req_chan,
   sds_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sds_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [sds_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [sds_pkg::PDATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import sds_pkg::*;

   cfg_type           cfg;
   mem_req_type       mem_req;
   logic [ADDR_W-1:0] rd_data;

   sds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sds_table_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   sds_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cfg      (cfg),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

endmodule

// File: rtl/sds_checker.sv
// ============================================================================
// sds_checker - port-level checks for the selector
// Watches the response channel and checks consistency of its fields.
// ============================================================================
module sds_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         connect_now,
   input logic                         newly_stored,
   input logic [sds_pkg::STORED_W-1:0] stored_count,
   input logic                         best_known,
   input logic [sds_pkg::RSSI_W-1:0]   best_strength
);
   import sds_pkg::*;

   // stalled response keeps its contents
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(stored_count) &&
      $stable(best_strength) && $stable(connect_now))
      else $error("response changed while stalled");

   // a report is never both stored and connected
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(connect_now && newly_stored))
      else $error("connect and store in one response");

   // count never exceeds the table size
   a_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> stored_count <= STORED_W'(TABLE_ENTRIES))
      else $error("stored count beyond table size");

   // no best yet means empty table and zero strength
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !best_known |-> stored_count == '0 && best_strength == '0)
      else $error("status fields inconsistent without a best device");

   // storing a device always establishes a best
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && newly_stored |-> best_known && stored_count != '0)
      else $error("new entry without best device");

endmodule

bind strongest_device_selector_unit sds_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .connect_now   (rsp_chan.connect_now),
   .newly_stored  (rsp_chan.newly_stored),
   .stored_count  (rsp_chan.stored_count),
   .best_known    (rsp_chan.best_known),
   .best_strength (rsp_chan.best_strength)
);
